/* rtl/sfs_pkg.sv */
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared constants for the sprite frame sequencer: operation codes, register
// indexes, the frame count limit, reset period and divider request type.
// ----------------------------------------------------------------------------
package sfs_pkg;

  localparam int MAX_FRAMES = 256;

  // Largest effective frame count, the smaller of the frame limit and 256.
  localparam logic [8:0] CNT_LIMIT = 9'((MAX_FRAMES < 256) ? MAX_FRAMES : 256);

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_START   = 3'd1;
  localparam logic [2:0] OP_PAUSE   = 3'd2;
  localparam logic [2:0] OP_RESTART = 3'd3;
  localparam logic [2:0] OP_SET     = 3'd4;

  localparam logic [2:0] REG_FRAME_WIDTH    = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_ORIGIN_X       = 3'd2;
  localparam logic [2:0] REG_ORIGIN_Y       = 3'd3;
  localparam logic [2:0] REG_FRAME_COUNT    = 3'd4;
  localparam logic [2:0] REG_FRAMES_PER_ROW = 3'd5;
  localparam logic [2:0] REG_FRAME_PERIOD   = 3'd6;
  localparam logic [2:0] REG_MODE           = 3'd7;

  localparam logic [23:0] PERIOD_RESET = 24'd100000;

  typedef struct packed {
    logic start;
    logic [7:0] dividend;
    logic [8:0] divisor;
  } div_req_t;

endpackage

/* rtl/sprite_frame_sequencer.sv */
// ----------------------------------------------------------------------------
// sprite_frame_sequencer
// Sprite-sheet animation sequencer: ticks accumulate time and advance the
// frame, and the source rectangle origin is recomputed through a shared
// bit-serial divider followed by one multiply-add step.
//
//   channel  direction  handshake             payload
//   evt      in         evt_valid/evt_stall   op, delta_us, frame_select
//   res      out        res_valid/res_stall   frame_now, source_x/y, running,
//                                             visible
//   cfg      in         cfg_we                cfg_index, cfg_data
//
// An event that moves to a new frame (advancing tick or set-frame) reaches the
// result register through the divider iterations, a step to see the divider
// finish, the multiply-add and the output load. Any other event goes straight
// to the output load. The next event is taken once the sequencer is back in
// idle after the output load.
// A synchronous reset restores settings and state, not the output payload.
// A stalled result holds the sequencer in its output step; evt_stall is high
// whenever the sequencer is not idle.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer
  import sfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        evt_valid,
  output logic        evt_stall,
  input  logic [2:0]  op,
  input  logic [19:0] delta_us,
  input  logic [7:0]  frame_select,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [7:0]  frame_now,
  output logic [19:0] source_x,
  output logic [19:0] source_y,
  output logic        running,
  output logic        visible,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [11:0] frame_width;
  logic [11:0] frame_height;
  logic [11:0] origin_x;
  logic [11:0] origin_y;
  logic [8:0]  frame_count;
  logic [8:0]  frames_per_row;
  logic [23:0] frame_period_us;
  logic [1:0]  mode;

  logic [1:0]  state;
  logic [24:0] elapsed_us;
  logic [7:0]  frame_reg;
  logic        running_flag;
  logic [19:0] src_x_reg;
  logic [19:0] src_y_reg;

  logic        accept;
  logic [24:0] sum;
  logic        advance;
  logic [8:0]  cnt_raw;
  logic [8:0]  cnt_eff;
  logic [8:0]  next_frame;
  logic        past_end;
  logic [7:0]  frame_next;
  logic        place;
  div_req_t    div_req;
  logic        div_done;
  logic [7:0]  div_quot;
  logic [7:0]  div_rem;
  logic        load_out;

  assign accept    = evt_valid && !evt_stall;
  assign evt_stall = (state != ST_IDLE);
  assign load_out  = (state == ST_OUT) && (!res_valid || !res_stall);

  always_comb begin
    sum        = elapsed_us + 25'(delta_us);
    advance    = running_flag && (sum >= {1'b0, frame_period_us});
    cnt_raw    = (frame_count == 9'd0) ? 9'd1 : frame_count;
    cnt_eff    = (cnt_raw > CNT_LIMIT) ? CNT_LIMIT : cnt_raw;
    next_frame = {1'b0, frame_reg} + 9'd1;
    past_end   = next_frame >= cnt_eff;
    if (op == OP_SET) begin
      frame_next = frame_select;
    end else if (past_end) begin
      frame_next = mode[0] ? 8'd0 : 8'(cnt_eff - 9'd1);
    end else begin
      frame_next = next_frame[7:0];
    end
    place = (op == OP_SET) || ((op == OP_TICK) && advance);
    div_req.start    = accept && place;
    div_req.dividend = frame_next;
    div_req.divisor  = (frames_per_row == 9'd0) ? 9'd1 : frames_per_row;
  end

  sfs_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot),
    .rem  (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= '0;
      frame_height    <= '0;
      origin_x        <= '0;
      origin_y        <= '0;
      frame_count     <= 9'd1;
      frames_per_row  <= 9'd1;
      frame_period_us <= PERIOD_RESET;
      mode            <= 2'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:    frame_width     <= cfg_data[11:0];
        REG_FRAME_HEIGHT:   frame_height    <= cfg_data[11:0];
        REG_ORIGIN_X:       origin_x        <= cfg_data[11:0];
        REG_ORIGIN_Y:       origin_y        <= cfg_data[11:0];
        REG_FRAME_COUNT:    frame_count     <= cfg_data[8:0];
        REG_FRAMES_PER_ROW: frames_per_row  <= cfg_data[8:0];
        REG_FRAME_PERIOD:   frame_period_us <= cfg_data;
        REG_MODE:           mode            <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      elapsed_us   <= '0;
      frame_reg    <= '0;
      running_flag <= 1'b0;
      src_x_reg    <= '0;
      src_y_reg    <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (load_out) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= place ? ST_DIV : ST_OUT;
            case (op)
              OP_TICK: begin
                if (running_flag) begin
                  // On reaching the period the sum is cleared, not reduced.
                  elapsed_us <= advance ? 25'd0 : sum;
                  if (advance) begin
                    frame_reg <= frame_next;
                    if (past_end && !mode[0]) begin
                      running_flag <= 1'b0;
                    end
                  end
                end
              end
              OP_START:   running_flag <= 1'b1;
              OP_PAUSE:   running_flag <= 1'b0;
              OP_RESTART: begin
                frame_reg  <= '0;
                elapsed_us <= '0;
              end
              OP_SET:     frame_reg <= frame_next;
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          src_x_reg <= 20'(origin_x) + 20'(div_rem) * 20'(frame_width);
          src_y_reg <= 20'(origin_y) + 20'(div_quot) * 20'(frame_height);
          state     <= ST_OUT;
        end
        ST_OUT: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      frame_now <= frame_reg;
      source_x  <= src_x_reg;
      source_y  <= src_y_reg;
      running   <= running_flag;
      visible   <= running_flag || mode[1];
    end
  end

  a_busy_stalls : assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> evt_stall)
    else $error("event taken while busy");

  a_accept_leaves_idle : assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("accepted word produced no work");

  a_result_from_out : assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == ST_OUT))
    else $error("result word raised outside the output step");

  a_div_only_when_placing : assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside the divide step");

endmodule

/* rtl/sfs_div.sv */
// ----------------------------------------------------------------------------
// sfs_div
// Restoring divider, one quotient bit per cycle: an 8-bit frame index divided
// by a 9-bit frames-per-row value, giving row and column.
// ----------------------------------------------------------------------------
module sfs_div
  import sfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  div_req_t   req,
  output logic       done,
  output logic [7:0] quot,
  output logic [7:0] rem
);

  logic [7:0] work;
  logic [7:0] part;
  logic [8:0] divisor;
  logic [2:0] count;
  logic       busy;
  logic [8:0] shifted;
  logic       fits;
  logic [8:0] diff;

  assign shifted = {part, work[7]};
  assign fits    = shifted >= divisor;
  assign diff    = shifted - divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        count   <= '0;
        work    <= req.dividend;
        part    <= '0;
        divisor <= req.divisor;
      end else if (busy) begin
        // The dividend shifts out at the top while quotient bits enter below.
        work  <= {work[6:0], fits};
        part  <= fits ? diff[7:0] : shifted[7:0];
        count <= count + 3'd1;
        if (count == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = work;
  assign rem  = part;

  a_done_after_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider finished without running");

  a_rem_below_divisor : assert property (@(posedge clk) disable iff (rst)
    done |-> ({1'b0, rem} < divisor))
    else $error("remainder not below divisor");

  a_busy_sticks : assert property (@(posedge clk) disable iff (rst)
    (busy && count != 3'd7 && !req.start) |=> busy)
    else $error("divider dropped busy early");

endmodule

/* sim/sprite_frame_sequencer_tb.sv */
// ----------------------------------------------------------------------------
// sprite_frame_sequencer_tb
// Self-checking bench for the sprite frame sequencer. A scoreboard object
// keeps its own copy of the sheet registers and the animation state, works
// out the frame and source rectangle each event word should produce and
// compares every result word against it. A short directed run covers the
// edge cases, then randomised event streams run under several register
// settings with the sender idling and the receiver stalling in turn.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer_tb;
  import sfs_pkg::*;

  localparam int          DELTA_MAX   = 1000000;
  localparam int          QUIET_LIMIT = 4000;
  localparam logic [2:0]  OP_SPARE_LO = 3'd5;
  localparam logic [2:0]  OP_SPARE_HI = 3'd7;
  localparam int unsigned MODE_HOLD      = 0;
  localparam int unsigned MODE_LOOP      = 1;
  localparam int unsigned MODE_SHOW      = 2;
  localparam int unsigned MODE_LOOP_SHOW = 3;

  typedef struct packed {
    logic [7:0]  frame;
    logic [19:0] x;
    logic [19:0] y;
    logic        run;
    logic        vis;
  } sprite_view_t;

  class sprite_scoreboard;
    logic [11:0] frame_w, frame_h, org_x, org_y;
    logic [8:0]  count_reg, per_row_reg;
    logic [23:0] period;
    logic [1:0]  mode_bits;
    logic [24:0] elapsed;
    logic [7:0]  frame;
    logic        run;
    logic [19:0] src_x, src_y;
    sprite_view_t views[$];
    int errors;

    function new();
      frame_w = '0;
      frame_h = '0;
      org_x = '0;
      org_y = '0;
      count_reg = 9'd1;
      per_row_reg = 9'd1;
      period = PERIOD_RESET;
      mode_bits = 2'(MODE_LOOP);
      elapsed = '0;
      frame = '0;
      run = 1'b0;
      src_x = '0;
      src_y = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] data);
      case (idx)
        REG_FRAME_WIDTH:    frame_w = data[11:0];
        REG_FRAME_HEIGHT:   frame_h = data[11:0];
        REG_ORIGIN_X:       org_x = data[11:0];
        REG_ORIGIN_Y:       org_y = data[11:0];
        REG_FRAME_COUNT:    count_reg = data[8:0];
        REG_FRAMES_PER_ROW: per_row_reg = data[8:0];
        REG_FRAME_PERIOD:   period = data;
        REG_MODE:           mode_bits = data[1:0];
        default: ;
      endcase
    endfunction

    function logic [8:0] frames_in_use();
      logic [8:0] c;
      c = (count_reg == 9'd0) ? 9'd1 : count_reg;
      if (c > CNT_LIMIT) c = CNT_LIMIT;
      return c;
    endfunction

    // The column is the frame modulo the row length, the row its quotient.
    function void place_frame();
      int unsigned per, col, row;
      per = (per_row_reg == 9'd0) ? 1 : per_row_reg;
      col = frame % per;
      row = frame / per;
      src_x = 20'(org_x + col * frame_w);
      src_y = 20'(org_y + row * frame_h);
    endfunction

    function void note_event(logic [2:0] code, logic [19:0] delta, logic [7:0] sel);
      logic [8:0] nxt, cnt;
      sprite_view_t want;
      case (code)
        OP_TICK: begin
          if (run) begin
            elapsed = elapsed + 25'(delta);
            // The accumulator is cleared on an advance, not reduced.
            if (elapsed >= 25'(period)) begin
              cnt = frames_in_use();
              nxt = 9'(frame) + 9'd1;
              elapsed = '0;
              if (nxt >= cnt) begin
                if (mode_bits[0]) begin
                  nxt = '0;
                end else begin
                  nxt = cnt - 9'd1;
                  run = 1'b0;
                end
              end
              frame = nxt[7:0];
              place_frame();
            end
          end
        end
        OP_START:   run = 1'b1;
        OP_PAUSE:   run = 1'b0;
        OP_RESTART: begin
          frame = '0;
          elapsed = '0;
        end
        OP_SET: begin
          frame = sel;
          place_frame();
        end
        default: ;
      endcase
      want.frame = frame;
      want.x = src_x;
      want.y = src_y;
      want.run = run;
      want.vis = run | mode_bits[1];
      views.push_back(want);
    endfunction

    function void check_view(logic [7:0] f, logic [19:0] x, logic [19:0] y,
                             logic r, logic v);
      sprite_view_t want;
      if (views.size() == 0) begin
        $error("result word with no expectation waiting");
        errors++;
        return;
      end
      want = views.pop_front();
      if (f !== want.frame) begin
        $error("frame_now: expected %0d, got %0d", want.frame, f);
        errors++;
      end
      if (x !== want.x) begin
        $error("source_x: expected %0d, got %0d", want.x, x);
        errors++;
      end
      if (y !== want.y) begin
        $error("source_y: expected %0d, got %0d", want.y, y);
        errors++;
      end
      if (r !== want.run) begin
        $error("running: expected %0d, got %0d", want.run, r);
        errors++;
      end
      if (v !== want.vis) begin
        $error("visible: expected %0d, got %0d", want.vis, v);
        errors++;
      end
    endfunction

    function int pending();
      return views.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        evt_valid = 1'b0;
  logic        evt_stall;
  logic [2:0]  op = OP_TICK;
  logic [19:0] delta_us = '0;
  logic [7:0]  frame_select = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [7:0]  frame_now;
  logic [19:0] source_x;
  logic [19:0] source_y;
  logic        running;
  logic        visible;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_FRAME_WIDTH;
  logic [23:0] cfg_data = '0;

  sprite_scoreboard sb;
  int idle_pct = 0;
  int stall_pct = 0;
  int unsigned cur_period = PERIOD_RESET;
  int unsigned sel_cap = 0;
  int quiet_cycles = 0;

  sprite_frame_sequencer dut (
    .clk(clk),
    .rst(rst),
    .evt_valid(evt_valid),
    .evt_stall(evt_stall),
    .op(op),
    .delta_us(delta_us),
    .frame_select(frame_select),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .frame_now(frame_now),
    .source_x(source_x),
    .source_y(source_y),
    .running(running),
    .visible(visible),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  // Monitor and watchdog: every handshake is sampled at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (evt_valid && !evt_stall) sb.note_event(op, delta_us, frame_select);
      if (res_valid && !res_stall)
        sb.check_view(frame_now, source_x, source_y, running, visible);
      if ((evt_valid && !evt_stall) || (res_valid && !res_stall) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Returns at the edge where the event word is taken.
  task automatic send_evt(input logic [2:0] code, input logic [19:0] delta,
                          input logic [7:0] sel);
    while ($urandom_range(99) < idle_pct) begin
      evt_valid <= 1'b0;
      @(posedge clk);
    end
    evt_valid <= 1'b1;
    op <= code;
    delta_us <= delta;
    frame_select <= sel;
    @(posedge clk);
    while (evt_stall) @(posedge clk);
  endtask

  task automatic drain();
    evt_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_regs(input int unsigned w, input int unsigned h,
                           input int unsigned x0, input int unsigned y0,
                           input int unsigned cnt, input int unsigned per_row,
                           input int unsigned period_us, input int unsigned md);
    int unsigned eff;
    put_reg(REG_FRAME_WIDTH, 24'(w));
    put_reg(REG_FRAME_HEIGHT, 24'(h));
    put_reg(REG_ORIGIN_X, 24'(x0));
    put_reg(REG_ORIGIN_Y, 24'(y0));
    put_reg(REG_FRAME_COUNT, 24'(cnt));
    put_reg(REG_FRAMES_PER_ROW, 24'(per_row));
    put_reg(REG_FRAME_PERIOD, 24'(period_us));
    put_reg(REG_MODE, 24'(md));
    cfg_we <= 1'b0;
    cur_period = period_us;
    eff = (cnt == 0) ? 1 : ((cnt > CNT_LIMIT) ? CNT_LIMIT : cnt);
    sel_cap = eff - 1;
  endtask

  // Mostly ticks with a start now and then to keep the animation moving;
  // tick sizes are scaled to the frame period so that frames do advance.
  task automatic random_events(input int n);
    logic [2:0]  code;
    logic [19:0] delta;
    logic [7:0]  sel;
    int unsigned pick, span;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 58) code = OP_TICK;
      else if (pick < 72) code = OP_START;
      else if (pick < 78) code = OP_PAUSE;
      else if (pick < 84) code = OP_RESTART;
      else if (pick < 96) code = OP_SET;
      else code = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
      span = (cur_period / 2 > DELTA_MAX) ? DELTA_MAX : cur_period / 2;
      if (span == 0) span = 1;
      case ($urandom_range(9))
        0:       delta = '0;
        1:       delta = 20'(DELTA_MAX);
        2, 3:    delta = 20'($urandom_range(DELTA_MAX));
        default: delta = 20'($urandom_range(span));
      endcase
      if ($urandom_range(1)) sel = 8'($urandom_range(255));
      else sel = 8'($urandom_range(sel_cap));
      send_evt(code, delta, sel);
    end
  endtask

  task automatic run_phase(input int k);
    case (k % 4)
      0: begin
        idle_pct = 0;
        stall_pct = 0;
      end
      1: begin
        idle_pct = 76;
        stall_pct = 0;
      end
      2: begin
        idle_pct = 0;
        stall_pct = 76;
      end
      default: begin
        idle_pct = 25;
        stall_pct = 25;
      end
    endcase
    case (k)
      0: load_regs(16, 24, 8, 4, 8, 4, 2000, MODE_LOOP);
      1: load_regs(4095, 4095, 4095, 4095, 256, 256, 0, MODE_HOLD);
      2: load_regs(0, 0, 0, 0, 0, 0, 1, MODE_SHOW);
      3: load_regs(4095, 4095, 4095, 4095, 511, 511, 24'hFFFFFF, MODE_LOOP_SHOW);
      4: load_regs($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                   $urandom_range(4095), $urandom_range(20, 1), $urandom_range(16, 1),
                   $urandom_range(300000, 1), $urandom_range(MODE_LOOP_SHOW));
      default: load_regs($urandom_range(4095), $urandom_range(4095),
                         $urandom_range(4095), $urandom_range(4095),
                         $urandom_range(511), $urandom_range(511),
                         $urandom_range(2000000), $urandom_range(MODE_LOOP_SHOW));
    endcase
    random_events(125);
    drain();
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Settings after reset: a single looping frame with a 100 ms period.
    send_evt(OP_TICK, 20'(DELTA_MAX), 8'd0);
    send_evt(OP_START, 20'd0, 8'd0);
    send_evt(OP_TICK, 20'd99999, 8'd0);
    send_evt(OP_TICK, 20'd1, 8'd0);
    send_evt(OP_PAUSE, 20'd0, 8'd0);
    drain();

    // Largest sheet, one frame per row, zero period, hold at the end.
    load_regs(4095, 4095, 4095, 4095, 256, 1, 0, MODE_HOLD);
    send_evt(OP_SET, 20'd0, 8'd255);
    send_evt(OP_START, 20'd0, 8'd0);
    send_evt(OP_TICK, 20'd0, 8'd0);
    send_evt(OP_RESTART, 20'd0, 8'd0);
    send_evt(OP_SPARE_LO, 20'(DELTA_MAX), 8'd255);
    send_evt(OP_SPARE_LO + 3'd1, 20'd0, 8'd0);
    send_evt(OP_SPARE_HI, 20'd0, 8'd0);
    drain();

    // Frame count above the limit is clamped; a 256-frame row; longest period.
    load_regs(4095, 4095, 4095, 4095, 511, 256, 24'hFFFFFF, MODE_LOOP_SHOW);
    send_evt(OP_SET, 20'd0, 8'd255);
    send_evt(OP_START, 20'd0, 8'd0);
    send_evt(OP_TICK, 20'(DELTA_MAX), 8'd0);
    send_evt(OP_RESTART, 20'd0, 8'd0);
    send_evt(OP_PAUSE, 20'd0, 8'd0);
    drain();

    // Zero count and zero row length behave as one; a frame beyond the count.
    load_regs(7, 5, 0, 0, 0, 0, 0, MODE_SHOW);
    send_evt(OP_SET, 20'd0, 8'd200);
    send_evt(OP_START, 20'd0, 8'd0);
    send_evt(OP_TICK, 20'd0, 8'd0);
    drain();

    load_regs(3, 3, 1, 1, 4, 2, 10, MODE_LOOP);
    send_evt(OP_START, 20'd0, 8'd0);
    send_evt(OP_TICK, 20'd10, 8'd0);
    send_evt(OP_TICK, 20'd9, 8'd0);
    send_evt(OP_TICK, 20'd1, 8'd0);
    send_evt(OP_SET, 20'd0, 8'd3);
    send_evt(OP_TICK, 20'd10, 8'd0);
    drain();

    for (int k = 0; k < 6; k++) run_phase(k);

    repeat (12) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
